@@ rtl/rcrp_pkg.sv @@
package rcrp_pkg;

  localparam int EASE_DEPTH_DEFAULT   = 1024;
  localparam int FACTOR_WIDTH_DEFAULT = 16;

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int TIME_DELTA_W = 16;
  localparam int ELAPSED_W    = 32;
  localparam int WEIGHT_W     = 16;

  localparam logic [ELAPSED_W-1:0] RAMP_DURATION_RESET = 32'd1000000;
  localparam logic [WEIGHT_W:0]    WEIGHT_ONE          = 17'h10000;
  localparam logic [63:0]          PI_Q30              = 64'd3373259426;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_RAMP_DURATION  = 2'd0;
  localparam cfg_index_t CFG_END_VERTICAL   = 2'd1;
  localparam cfg_index_t CFG_END_HORIZONTAL = 2'd2;

  typedef enum logic [1:0] {
    RS_IDLE = 2'd0,
    RS_RUN  = 2'd1,
    RS_DONE = 2'd2
  } ramp_stage_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV,
    ST_ROM,
    ST_BLEND,
    ST_ROUND,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_td;
    logic capture;
    logic accum;
    logic div_start;
    logic div_step;
    logic rom_read;
    logic w_full;
    logic blend_mul;
    logic round;
    logic emit;
    logic emit_end;
  } dp_cmd_t;

  typedef struct packed {
    logic elapsed_gt;
    logic elapsed_eq;
    logic div_last;
  } dp_status_t;

  // sin^2 of an angle in Q30 over [0, pi/2], rounded to Q16 and capped below one
  function automatic logic [WEIGHT_W-1:0] ease_weight(input logic [63:0] ang);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        s;
    logic [63:0]        w;
    logic signed [63:0] acc;
    x2   = (ang * ang) >> 30;
    term = ang;
    acc  = signed'(ang);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - signed'(term);
    if (acc < 0) begin
      acc = '0;
    end
    s = unsigned'(acc);
    w = (s * s + (64'd1 << 43)) >> 44;
    if (w > 64'd65535) begin
      w = 64'd65535;
    end
    return w[WEIGHT_W-1:0];
  endfunction

endpackage

@@ rtl/rcrp_ctrl.sv @@
module rcrp_ctrl
  import rcrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  ramp_stage_t stage_r, stage_nxt;
  logic        out_valid_r;
  logic        emit_go;

  assign emit_go = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= RS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      if (state_r == ST_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (stage_r)
            RS_IDLE: begin
              stage_nxt = RS_RUN;
              state_nxt = ST_EMIT;
            end
            RS_RUN:  state_nxt = ST_ACCUM;
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_ACCUM: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (status.elapsed_gt) begin
          stage_nxt = RS_DONE;
          state_nxt = ST_EMIT;
        end else if (status.elapsed_eq) begin
          state_nxt = ST_BLEND;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ST_ROM;
        end
      end
      ST_ROM:   state_nxt = ST_BLEND;
      ST_BLEND: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    out_valid = out_valid_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load_td = in_valid;
        cmd.capture = in_valid && (stage_r == RS_IDLE);
      end
      ST_ACCUM: cmd.accum = 1'b1;
      ST_CHECK: begin
        cmd.div_start = !status.elapsed_gt && !status.elapsed_eq;
        cmd.w_full    = !status.elapsed_gt && status.elapsed_eq;
      end
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_ROM:   cmd.rom_read  = 1'b1;
      ST_BLEND: cmd.blend_mul = 1'b1;
      ST_ROUND: cmd.round     = 1'b1;
      ST_EMIT: begin
        cmd.emit     = emit_go;
        cmd.emit_end = (stage_r != RS_RUN);
      end
      default: cmd = '0;
    endcase
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r == RS_DONE |=> stage_r == RS_DONE)
    else $error("ramp left the finished stage");

  a_overrun_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK && status.elapsed_gt |=> state_r == ST_EMIT && stage_r == RS_DONE)
    else $error("elapsed past duration did not finish the ramp");

  a_div_to_rom: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && status.div_last |=> state_r == ST_ROM)
    else $error("division did not hand over to the table read");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && emit_go |=> out_valid_r && state_r == ST_IDLE)
    else $error("emitted beat not presented");

endmodule

@@ rtl/rcrp_datapath.sv @@
module rcrp_datapath
  import rcrp_pkg::*;
#(
  parameter int EASE_TABLE_DEPTH = EASE_DEPTH_DEFAULT,
  parameter int FACTOR_WIDTH     = FACTOR_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  cfg_index_t                     cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic [TIME_DELTA_W-1:0]        in_time_delta,
  input  logic signed [FACTOR_WIDTH-1:0] in_current_vertical,
  input  logic signed [FACTOR_WIDTH-1:0] in_current_horizontal,
  input  dp_cmd_t                        cmd,
  output dp_status_t                     status,
  output logic signed [FACTOR_WIDTH-1:0] out_vertical_factor,
  output logic signed [FACTOR_WIDTH-1:0] out_horizontal_factor,
  output logic                           out_ongoing
);

  localparam int QW  = $clog2(EASE_TABLE_DEPTH);
  localparam int CW  = $clog2(QW);
  localparam int PW  = ELAPSED_W + QW;
  localparam int FW  = FACTOR_WIDTH;
  localparam int DW  = FW + 1;
  localparam int BPW = FW + 19;
  localparam logic signed [BPW-1:0] HALF = BPW'(1) << (WEIGHT_W - 1);

  logic [WEIGHT_W-1:0] ease_rom [EASE_TABLE_DEPTH];

  for (genvar g = 0; g < EASE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] ANG = (PI_Q30 * 64'(g)) / (64'd2 * 64'(EASE_TABLE_DEPTH));
    assign ease_rom[g] = ease_weight(ANG);
  end

  logic [ELAPSED_W-1:0]    dur_r;
  logic signed [FW-1:0]    end_v_r, end_h_r;
  logic [ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic [TIME_DELTA_W-1:0] td_r;
  logic signed [FW-1:0]    start_v_r, start_h_r;
  logic signed [FW-1:0]    res_v_r, res_h_r;
  logic [ELAPSED_W-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]           lo_r;
  logic [QW-1:0]           quot_r;
  logic [CW-1:0]           cnt_r;
  logic [WEIGHT_W:0]       w_r;
  logic signed [BPW-1:0]   pv_r, ph_r;
  logic signed [FW-1:0]    out_v_r, out_h_r;
  logic                    ongoing_r;

  logic [ELAPSED_W:0]      elapsed_sum;
  logic [PW-1:0]           prod_full;
  logic [ELAPSED_W:0]      rem2;
  logic                    q_bit;
  logic signed [DW-1:0]    diff_v, diff_h;
  logic signed [17:0]      w_s;
  logic signed [BPW-1:0]   q_v, q_h;

  assign elapsed_sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(td_r);
  assign elapsed_nxt = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

  assign prod_full = PW'(elapsed_r) * PW'(EASE_TABLE_DEPTH);

  assign rem2    = {rem_r, lo_r[QW-1]};
  assign q_bit   = (rem2 >= {1'b0, dur_r});
  assign rem_nxt = q_bit ? ELAPSED_W'(rem2 - {1'b0, dur_r}) : rem2[ELAPSED_W-1:0];

  assign diff_v = DW'(end_v_r) - DW'(start_v_r);
  assign diff_h = DW'(end_h_r) - DW'(start_h_r);
  assign w_s    = signed'({1'b0, w_r});

  assign q_v = (pv_r + HALF) >>> WEIGHT_W;
  assign q_h = (ph_r + HALF) >>> WEIGHT_W;

  assign status.elapsed_gt = (elapsed_r > dur_r);
  assign status.elapsed_eq = (elapsed_r == dur_r);
  assign status.div_last   = (cnt_r == CW'(QW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r     <= RAMP_DURATION_RESET;
      end_v_r   <= '0;
      end_h_r   <= '0;
      elapsed_r <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_RAMP_DURATION:  dur_r   <= cfg_data;
          CFG_END_VERTICAL:   end_v_r <= cfg_data[FW-1:0];
          CFG_END_HORIZONTAL: end_h_r <= cfg_data[FW-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        elapsed_r <= '0;
      end else if (cmd.accum) begin
        elapsed_r <= elapsed_nxt;
      end
      if (cmd.div_start) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_td) begin
      td_r <= in_time_delta;
    end
    if (cmd.capture) begin
      start_v_r <= in_current_vertical;
      start_h_r <= in_current_horizontal;
    end
    if (cmd.div_start) begin
      rem_r  <= prod_full[PW-1:QW];
      lo_r   <= prod_full[QW-1:0];
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      lo_r   <= lo_r << 1;
      quot_r <= {quot_r[QW-2:0], q_bit};
    end
    if (cmd.rom_read) begin
      w_r <= {1'b0, ease_rom[quot_r]};
    end else if (cmd.w_full) begin
      w_r <= WEIGHT_ONE;
    end
    if (cmd.blend_mul) begin
      pv_r <= BPW'(diff_v) * BPW'(w_s);
      ph_r <= BPW'(diff_h) * BPW'(w_s);
    end
    if (cmd.capture) begin
      res_v_r <= in_current_vertical;
      res_h_r <= in_current_horizontal;
    end else if (cmd.round) begin
      res_v_r <= start_v_r + q_v[FW-1:0];
      res_h_r <= start_h_r + q_h[FW-1:0];
    end
    if (cmd.emit) begin
      out_v_r   <= cmd.emit_end ? end_v_r : res_v_r;
      out_h_r   <= cmd.emit_end ? end_h_r : res_h_r;
      ongoing_r <= !cmd.emit_end;
    end
  end

  assign out_vertical_factor   = out_v_r;
  assign out_horizontal_factor = out_h_r;
  assign out_ongoing           = ongoing_r;

endmodule

@@ rtl/raised_cosine_ramp_pair.sv @@
// Raised-cosine ramp for a pair of signed Q8.8 factors, one beat per frame tick.
// Input channel (in_valid / in_stall): time since the last tick and the two present
// factors. Result channel (out_valid / out_stall): the two new factors and an
// ongoing flag. Configuration (cfg_write_en / cfg_index / cfg_data): ramp duration
// in microseconds and the two end values; write only while no beat is in flight.
// The first tick captures the factors as start values and echoes them. Later ticks
// add the frame time to a saturating elapsed counter and blend start to end with
// the weight (1 - cos(pi * elapsed / duration)) / 2 from a registered lookup table.
// Once elapsed passes duration the end values go out with ongoing low, for good.
// Steps: a running tick adds the frame time, checks elapsed against duration, forms
// the table index in a bit-serial divider, one quotient bit a cycle, reads the table,
// blends, rounds and emits; a tick that lands on the duration skips the divider and
// the table read, the tick that ends the ramp goes from the check straight to emit,
// and first and finished ticks go straight to emit. One beat is worked on at a time;
// the next is accepted once the current result is in the output register.
// A stalled result holds in the output register; the block then waits in its last
// step until the register frees. Reset (synchronous, rst_n low) restores the
// configuration defaults, clears the ramp to not started and drops out_valid.
module raised_cosine_ramp_pair
  import rcrp_pkg::*;
#(
  parameter int EASE_TABLE_DEPTH = EASE_DEPTH_DEFAULT,
  parameter int FACTOR_WIDTH     = FACTOR_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  cfg_index_t                     cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [TIME_DELTA_W-1:0]        in_time_delta,
  input  logic signed [FACTOR_WIDTH-1:0] in_current_vertical,
  input  logic signed [FACTOR_WIDTH-1:0] in_current_horizontal,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [FACTOR_WIDTH-1:0] out_vertical_factor,
  output logic signed [FACTOR_WIDTH-1:0] out_horizontal_factor,
  output logic                           out_ongoing
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rcrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rcrp_datapath #(
    .EASE_TABLE_DEPTH (EASE_TABLE_DEPTH),
    .FACTOR_WIDTH     (FACTOR_WIDTH)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_time_delta         (in_time_delta),
    .in_current_vertical   (in_current_vertical),
    .in_current_horizontal (in_current_horizontal),
    .cmd                   (cmd),
    .status                (status),
    .out_vertical_factor   (out_vertical_factor),
    .out_horizontal_factor (out_horizontal_factor),
    .out_ongoing           (out_ongoing)
  );

endmodule
